// ===== hdl/wf3_pkg.sv =====
// Shared types, constants and compare helpers for the 3x3 window filter.
package wf3_pkg;

   localparam int PIX_W       = 8;
   localparam int COORD_W     = 10;
   localparam int CFG_W       = 11;
   localparam int WIN_N       = 9;
   localparam int QUEUE_DEPTH = 4;
   localparam int QCNT_W      = 3;
   localparam int SUM_W       = 12;
   localparam int MEAN_RECIP  = 7282;   // round-up of 2^16 / 9
   localparam int MEAN_SHIFT  = 16;
   localparam int PROD_W      = 25;
   localparam int MIN_SIZE    = 4;

   typedef logic [PIX_W-1:0]   pix_type;
   typedef logic [COORD_W-1:0] coord_type;

   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_FILTER_MODE  = 2'd2
   } csr_idx_type;

   // One completed window plus where its results go.
   typedef struct packed {
      pix_type [WIN_N-1:0] win;
      logic                col_first;
      logic                col_last;
      logic                row_first;
      logic                row_last;
      coord_type           col;
      coord_type           row;
   } job_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QCNT_W-1:0] count;
   } qstat_type;

   function automatic pix_type pmin(input pix_type a, input pix_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic pix_type pmax(input pix_type a, input pix_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic pix_type min3(input pix_type a, input pix_type b, input pix_type c);
      return pmin(pmin(a, b), c);
   endfunction

   function automatic pix_type max3(input pix_type a, input pix_type b, input pix_type c);
      return pmax(pmax(a, b), c);
   endfunction

   function automatic pix_type med3(input pix_type a, input pix_type b, input pix_type c);
      return pmax(pmin(a, b), pmin(pmax(a, b), c));
   endfunction

endpackage

// ===== hdl/wf3_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wf3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/wf3_front.sv =====
// Front end: pixel position, line stores, window shift and job classification.
module wf3_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  wf3_pkg::pix_type          pixel_in,
   input  logic                      frame_start,
   input  logic [wf3_pkg::CFG_W-1:0] frame_width,
   input  logic [wf3_pkg::CFG_W-1:0] frame_height,
   output logic                      busy,
   output logic                      push,
   output wf3_pkg::job_type          job
);

   localparam int STORE_DEPTH = (MAX_WIDTH < 4) ? 4 : MAX_WIDTH;
   localparam int ROW_LIMIT   = (MAX_HEIGHT < 4) ? 4 : MAX_HEIGHT;
   localparam int AW  = $clog2(STORE_DEPTH);
   localparam int CW  = $clog2(STORE_DEPTH + 1);
   localparam int RW  = $clog2(ROW_LIMIT + 1);
   localparam int SWC = (CW > wf3_pkg::CFG_W) ? CW : wf3_pkg::CFG_W;
   localparam int SWR = (RW > wf3_pkg::CFG_W) ? RW : wf3_pkg::CFG_W;

   logic [CW-1:0] w;
   logic [RW-1:0] h;
   logic [SWC-1:0] fw_ext;
   logic [SWR-1:0] fh_ext;

   // clamp sizes to 4..limit
   always_comb begin
      fw_ext = SWC'(frame_width);
      fh_ext = SWR'(frame_height);
      if (fw_ext > SWC'(STORE_DEPTH)) begin
         w = CW'(STORE_DEPTH);
      end else if (fw_ext < SWC'(wf3_pkg::MIN_SIZE)) begin
         w = CW'(wf3_pkg::MIN_SIZE);
      end else begin
         w = CW'(fw_ext);
      end
      if (fh_ext > SWR'(ROW_LIMIT)) begin
         h = RW'(ROW_LIMIT);
      end else if (fh_ext < SWR'(wf3_pkg::MIN_SIZE)) begin
         h = RW'(wf3_pkg::MIN_SIZE);
      end else begin
         h = RW'(fh_ext);
      end
   end

   logic [CW-1:0] col_ff, col_in, col_cur, col_nx;
   logic [RW-1:0] row_ff, row_in, row_cur, row_nx;

   always_comb begin
      col_cur = frame_start ? '0 : col_ff;
      row_cur = frame_start ? '0 : row_ff;
      if (col_cur >= w) begin
         col_cur = '0;
         row_cur = row_cur + RW'(1);
      end
      if (row_cur >= h) begin
         row_cur = '0;
      end
      col_nx = col_cur + CW'(1);
      row_nx = row_cur;
      if (col_nx >= w) begin
         col_nx = '0;
         row_nx = row_cur + RW'(1);
         if (row_nx >= h) begin
            row_nx = '0;
         end
      end
      col_in = accept ? col_nx : col_ff;
      row_in = accept ? row_nx : row_ff;
   end

   // stage 1: line store data is back, window shifts
   logic                 s1_valid_ff;
   logic                 s1_fwd_ff;
   logic [AW-1:0]        s1_addr_ff;
   wf3_pkg::pix_type     s1_pix_ff;
   logic                 s1_rge1_ff, s1_rge2_ff, s1_cge2_ff;
   logic                 s1_cfirst_ff, s1_clast_ff, s1_rfirst_ff, s1_rlast_ff;
   wf3_pkg::coord_type   s1_col_ff, s1_row_ff;
   wf3_pkg::pix_type     fwd_upper_ff, fwd_lower_ff;
   wf3_pkg::pix_type [wf3_pkg::WIN_N-1:0] win_ff, win_in;

   logic [AW-1:0]    rd_addr;
   wf3_pkg::pix_type upper_rd, lower_rd, upper_eff, lower_eff;

   assign rd_addr = col_cur[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         win_ff      <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
         win_ff      <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_fwd_ff    <= s1_valid_ff && (s1_addr_ff == rd_addr);
         s1_addr_ff   <= rd_addr;
         s1_pix_ff    <= pixel_in;
         s1_rge1_ff   <= row_cur >= RW'(1);
         s1_rge2_ff   <= row_cur >= RW'(2);
         s1_cge2_ff   <= col_cur >= CW'(2);
         s1_cfirst_ff <= col_cur == CW'(2);
         s1_clast_ff  <= col_cur == (w - CW'(1));
         s1_rfirst_ff <= row_cur == RW'(2);
         s1_rlast_ff  <= row_cur == (h - RW'(1));
         s1_col_ff    <= wf3_pkg::COORD_W'(col_cur);
         s1_row_ff    <= wf3_pkg::COORD_W'(row_cur);
      end
      if (s1_valid_ff) begin
         fwd_lower_ff <= s1_pix_ff;
         fwd_upper_ff <= s1_rge1_ff ? lower_eff : upper_eff;
      end
   end

   wf3_ram #(.WIDTH(wf3_pkg::PIX_W), .DEPTH(STORE_DEPTH)) u_upper (
      .clock (clock),
      .we    (s1_valid_ff && s1_rge1_ff),
      .waddr (s1_addr_ff),
      .wdata (lower_eff),
      .re    (accept),
      .raddr (rd_addr),
      .rdata (upper_rd)
   );

   wf3_ram #(.WIDTH(wf3_pkg::PIX_W), .DEPTH(STORE_DEPTH)) u_lower (
      .clock (clock),
      .we    (s1_valid_ff),
      .waddr (s1_addr_ff),
      .wdata (s1_pix_ff),
      .re    (accept),
      .raddr (rd_addr),
      .rdata (lower_rd)
   );

   // back-to-back hit on the address written last cycle
   assign upper_eff = s1_fwd_ff ? fwd_upper_ff : upper_rd;
   assign lower_eff = s1_fwd_ff ? fwd_lower_ff : lower_rd;

   always_comb begin
      win_in = win_ff;
      if (s1_valid_ff) begin
         for (int k = 0; k < 3; k++) begin
            win_in[k*3]   = win_ff[k*3+1];
            win_in[k*3+1] = win_ff[k*3+2];
         end
         win_in[2] = s1_rge2_ff ? upper_eff : '0;
         win_in[5] = s1_rge1_ff ? lower_eff : '0;
         win_in[8] = s1_pix_ff;
      end
   end

   assign busy = s1_valid_ff;
   assign push = s1_valid_ff && s1_cge2_ff && s1_rge2_ff;

   always_comb begin
      job.win       = win_in;
      job.col_first = s1_cfirst_ff;
      job.col_last  = s1_clast_ff;
      job.row_first = s1_rfirst_ff;
      job.row_last  = s1_rlast_ff;
      job.col       = s1_col_ff;
      job.row       = s1_row_ff;
   end

endmodule

// ===== hdl/wf3_fifo.sv =====
// Short job queue between front end and back end.
module wf3_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  wf3_pkg::job_type   push_job,
   input  logic               pop,
   output wf3_pkg::job_type   head,
   output wf3_pkg::qstat_type stat
);

   localparam int PW = $clog2(wf3_pkg::QUEUE_DEPTH);

   wf3_pkg::job_type             mem_ff [wf3_pkg::QUEUE_DEPTH];
   logic [PW-1:0]                wr_ptr_ff, rd_ptr_ff;
   logic [wf3_pkg::QCNT_W-1:0]   count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + wf3_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - wf3_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head       = mem_ff[rd_ptr_ff];
   assign stat.count = count_ff;
   assign stat.empty = count_ff == '0;
   assign stat.full  = count_ff == wf3_pkg::QCNT_W'(wf3_pkg::QUEUE_DEPTH);

endmodule

// ===== hdl/wf3_back.sv =====
// Back end: median/mean pipeline and expansion into border-replicated results.
module wf3_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                filter_mode,
   input  logic                q_empty,
   input  wf3_pkg::job_type    head,
   output logic                pop,
   output logic                out_valid,
   input  logic                out_ready,
   output wf3_pkg::pix_type    pixel_out,
   output wf3_pkg::coord_type  out_column,
   output wf3_pkg::coord_type  out_row,
   output logic                run_last,
   output logic                frame_done
);

   typedef struct packed {
      logic               col_first;
      logic               col_last;
      logic               row_first;
      logic               row_last;
      wf3_pkg::coord_type col;
      wf3_pkg::coord_type row;
   } meta_type;

   logic advance;
   logic em_last;

   // stage A: sort each column, column sums
   logic                 a_valid_ff;
   meta_type             a_meta_ff;
   wf3_pkg::pix_type [2:0] a_lo_ff, a_mid_ff, a_hi_ff;
   logic [9:0]           a_sum_ff [3];

   // stage B: max of lows, median of mids, min of highs; total
   logic                 b_valid_ff;
   meta_type             b_meta_ff;
   wf3_pkg::pix_type     b_lo_ff, b_mid_ff, b_hi_ff;
   logic [wf3_pkg::SUM_W-1:0] b_sum_ff;

   // emit register
   logic                 em_valid_ff;
   meta_type             em_meta_ff;
   wf3_pkg::pix_type     em_val_ff, em_val_in;
   logic                 em_j_ff, em_i_ff;
   logic [wf3_pkg::PROD_W-1:0] mean_prod;

   assign advance = !em_valid_ff || (out_ready && em_last);
   assign pop     = advance && !q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff  <= 1'b0;
         b_valid_ff  <= 1'b0;
         em_valid_ff <= 1'b0;
         em_j_ff     <= 1'b0;
         em_i_ff     <= 1'b0;
      end else begin
         if (advance) begin
            a_valid_ff  <= !q_empty;
            b_valid_ff  <= a_valid_ff;
            em_valid_ff <= b_valid_ff;
            em_j_ff     <= 1'b0;
            em_i_ff     <= 1'b0;
         end else if (out_ready) begin
            // step through columns, then rows
            if (em_j_ff || !(em_meta_ff.col_first || em_meta_ff.col_last)) begin
               em_j_ff <= 1'b0;
               em_i_ff <= 1'b1;
            end else begin
               em_j_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_meta_ff <= '{col_first: head.col_first, col_last: head.col_last,
                        row_first: head.row_first, row_last: head.row_last,
                        col: head.col, row: head.row};
         for (int j = 0; j < 3; j++) begin
            a_lo_ff[j]  <= wf3_pkg::min3(head.win[j], head.win[3+j], head.win[6+j]);
            a_mid_ff[j] <= wf3_pkg::med3(head.win[j], head.win[3+j], head.win[6+j]);
            a_hi_ff[j]  <= wf3_pkg::max3(head.win[j], head.win[3+j], head.win[6+j]);
            a_sum_ff[j] <= 10'(head.win[j]) + 10'(head.win[3+j]) + 10'(head.win[6+j]);
         end
         b_meta_ff <= a_meta_ff;
         b_lo_ff   <= wf3_pkg::max3(a_lo_ff[0], a_lo_ff[1], a_lo_ff[2]);
         b_mid_ff  <= wf3_pkg::med3(a_mid_ff[0], a_mid_ff[1], a_mid_ff[2]);
         b_hi_ff   <= wf3_pkg::min3(a_hi_ff[0], a_hi_ff[1], a_hi_ff[2]);
         b_sum_ff  <= wf3_pkg::SUM_W'(a_sum_ff[0]) + wf3_pkg::SUM_W'(a_sum_ff[1])
                      + wf3_pkg::SUM_W'(a_sum_ff[2]);
         em_meta_ff <= b_meta_ff;
         em_val_ff  <= em_val_in;
      end
   end

   // sum / 9 by reciprocal; exact for sums up to 2295
   assign mean_prod = wf3_pkg::PROD_W'(b_sum_ff) * wf3_pkg::PROD_W'(wf3_pkg::MEAN_RECIP);
   assign em_val_in = filter_mode
                      ? mean_prod[wf3_pkg::MEAN_SHIFT +: wf3_pkg::PIX_W]
                      : wf3_pkg::med3(b_lo_ff, b_mid_ff, b_hi_ff);

   logic two_cols, two_rows;
   assign two_cols = em_meta_ff.col_first || em_meta_ff.col_last;
   assign two_rows = em_meta_ff.row_first || em_meta_ff.row_last;
   assign em_last  = (em_j_ff || !two_cols) && (em_i_ff || !two_rows);

   always_comb begin
      if (em_meta_ff.col_first && !em_j_ff) begin
         out_column = '0;
      end else if (em_meta_ff.col_last && em_j_ff) begin
         out_column = em_meta_ff.col;
      end else begin
         out_column = em_meta_ff.col - wf3_pkg::COORD_W'(1);
      end
      if (em_meta_ff.row_first && !em_i_ff) begin
         out_row = '0;
      end else if (em_meta_ff.row_last && em_i_ff) begin
         out_row = em_meta_ff.row;
      end else begin
         out_row = em_meta_ff.row - wf3_pkg::COORD_W'(1);
      end
   end

   assign out_valid  = em_valid_ff;
   assign pixel_out  = em_val_ff;
   assign run_last   = em_last;
   assign frame_done = em_meta_ff.col_last && em_j_ff && em_meta_ff.row_last && em_i_ff;

endmodule

// ===== hdl/window_filter_3x3_core.sv =====
// Top level of the streaming 3x3 median / mean window filter.
//
// Takes one 8-bit pixel per word in raster order and returns filtered pixels with their
// coordinates: the median (filter_mode 0) or truncated mean (filter_mode 1) of the
// 3x3 neighborhood, with border rows, columns and corners copying the nearest
// interior result. Sizes are clamped to 4..MAX. The input side takes one pixel per
// clock; a pixel that completes a window yields one result, two on the first or last
// interior row or column and four at a corner, each sent as its own output word. A
// four-entry job queue between the position/line-store front end and the filter back
// end absorbs those border bursts, so input stalls only when the queue fills. From
// the accepting edge to rsp_tvalid a pixel passes the line-store read with window shift,
// the job queue and two compare stages into the result register. Line stores need
// no clearing after reset.
module window_filter_3x3_core #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // slave side
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel_in
   input  logic [0:0]  req_tuser,   // [0] frame_start
   // master side
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] pixel_out, [17:8] out_column, [27:18] out_row
   output logic        rsp_tlast,   // run_last
   output logic [0:0]  rsp_tuser,   // [0] frame_done
   // register writes
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata
);

   logic [wf3_pkg::CFG_W-1:0] frame_width_ff, frame_height_ff;
   logic                      filter_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= wf3_pkg::CFG_W'(640);
         frame_height_ff <= wf3_pkg::CFG_W'(480);
         filter_mode_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            wf3_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            wf3_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            wf3_pkg::CSR_FILTER_MODE:  filter_mode_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic               accept;
   logic               front_busy;
   logic               push;
   logic               pop;
   wf3_pkg::job_type   push_job, head;
   wf3_pkg::qstat_type qstat;
   wf3_pkg::pix_type   pixel_out;
   wf3_pkg::coord_type out_column, out_row;
   logic               run_last, frame_done;

   // room for the queued jobs plus the one still in the front end; closed in reset
   assign req_tready = !reset
                       && (({1'b0, qstat.count} + {3'b0, front_busy})
                           < (wf3_pkg::QCNT_W + 1)'(wf3_pkg::QUEUE_DEPTH));
   assign accept = req_tvalid && req_tready;

   wf3_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .pixel_in     (req_tdata),
      .frame_start  (req_tuser[0]),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .busy         (front_busy),
      .push         (push),
      .job          (push_job)
   );

   wf3_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .stat     (qstat)
   );

   wf3_back u_back (
      .clock       (clock),
      .reset       (reset),
      .filter_mode (filter_mode_ff),
      .q_empty     (qstat.empty),
      .head        (head),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .pixel_out   (pixel_out),
      .out_column  (out_column),
      .out_row     (out_row),
      .run_last    (run_last),
      .frame_done  (frame_done)
   );

   assign rsp_tdata    = {4'b0, out_row, out_column, pixel_out};
   assign rsp_tlast    = run_last;
   assign rsp_tuser[0] = frame_done;

   // queue never overflows: ready accounts for the job in flight
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && qstat.full && !pop))
      else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && qstat.empty))
      else $error("job queue underflow");

   // frame end is always the last result of its pixel
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> rsp_tlast)
      else $error("frame_done without run_last");

   // accepted pixel reaches the window stage next cycle
   a_front_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> front_busy)
      else $error("front stage lost a pixel");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the streaming 3x3 median / mean window filter.
`timescale 1ns / 1ps

module testbench;

   localparam int MAX_W      = 1024;
   localparam int MAX_H      = 1024;
   localparam int STALL_MAX  = 5000;  // cycles with no word moving on either side
   localparam int DRAIN_WAIT = 30;    // margin for the pipeline to go quiet after the last result

   // one filtered pixel as it leaves the block
   typedef struct {
      wf3_pkg::pix_type   pix;
      wf3_pkg::coord_type col;
      wf3_pkg::coord_type row;
      logic               last;
      logic               done;
   } filt_word_type;

   // directed row: pixel, frame_start, and the filtered value where it is obvious
   typedef struct {
      int   pix;
      logic fs;
      int   want;   // -1: predictor only
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [10:0] csr_wdata = '0;

   always #4 clock = ~clock;

   window_filter_3x3_core #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) u_dut (.*);

   // ---------------------------------------------------------------
   // Filter predictor: own copy of the registers, stores and window
   // ---------------------------------------------------------------
   int unsigned        shadow_width, shadow_height;
   logic               shadow_mode;
   wf3_pkg::pix_type   upper_line [MAX_W];
   wf3_pkg::pix_type   lower_line [MAX_W];
   wf3_pkg::pix_type   win_px [9];
   int unsigned        next_col, next_row;

   filt_word_type pending_q [$];   // filtered pixels still owed by the block

   int          errors;
   int          words_in, words_out, frames_seen;
   int          send_idle_pct, recv_stall_pct;
   int          hold_left;

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned lim);
      if (v > lim) v = lim;
      if (v < wf3_pkg::MIN_SIZE) v = wf3_pkg::MIN_SIZE;
      return v;
   endfunction

   function automatic wf3_pkg::pix_type window_median();
      int s [9];
      int t, j;
      foreach (win_px[i]) s[i] = win_px[i];
      for (int i = 1; i < 9; i++) begin
         t = s[i];
         j = i - 1;
         while (j >= 0 && s[j] > t) begin
            s[j+1] = s[j];
            j--;
         end
         s[j+1] = t;
      end
      return wf3_pkg::pix_type'(s[4]);
   endfunction

   function automatic wf3_pkg::pix_type window_mean();
      int sum;
      sum = 0;
      foreach (win_px[i]) sum += win_px[i];
      return wf3_pkg::pix_type'(sum / 9);
   endfunction

   // Advances the model by one pixel and queues the results it owes; returns their count.
   function automatic int filter_pixel(wf3_pkg::pix_type pix, logic fs);
      int unsigned      w, h, c, r;
      int unsigned      cols [2], rows [2];
      int               nc, nr, n;
      wf3_pkg::pix_type v;
      filt_word_type    fw;
      w = clamp_dim(shadow_width, MAX_W);
      h = clamp_dim(shadow_height, MAX_H);
      n = 0;
      if (fs) begin
         next_col = 0;
         next_row = 0;
      end
      if (next_col >= w) begin
         next_col = 0;
         next_row++;
      end
      if (next_row >= h) next_row = 0;
      c = next_col;
      r = next_row;

      for (int k = 0; k < 3; k++) begin
         win_px[k*3]   = win_px[k*3+1];
         win_px[k*3+1] = win_px[k*3+2];
      end
      win_px[2] = (r >= 2) ? upper_line[c] : '0;
      win_px[5] = (r >= 1) ? lower_line[c] : '0;
      win_px[8] = pix;
      if (r >= 1) upper_line[c] = lower_line[c];
      lower_line[c] = pix;

      if (c >= 2 && r >= 2) begin
         v  = shadow_mode ? window_mean() : window_median();
         nc = 0;
         nr = 0;
         // border columns/rows replicate the nearest interior value
         if (c == 2) begin
            cols[nc] = 0;
            nc = nc + 1;
         end
         cols[nc] = c - 1;
         nc = nc + 1;
         if (c == w - 1 && nc < 2) begin
            cols[nc] = w - 1;
            nc = nc + 1;
         end
         if (r == 2) begin
            rows[nr] = 0;
            nr = nr + 1;
         end
         rows[nr] = r - 1;
         nr = nr + 1;
         if (r == h - 1 && nr < 2) begin
            rows[nr] = h - 1;
            nr = nr + 1;
         end
         for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
               fw.pix  = v;
               fw.col  = wf3_pkg::coord_type'(cols[j]);
               fw.row  = wf3_pkg::coord_type'(rows[i]);
               fw.done = (cols[j] == w - 1 && rows[i] == h - 1);
               fw.last = (i == nr - 1 && j == nc - 1);
               pending_q.push_back(fw);
               n++;
            end
         end
      end

      next_col++;
      if (next_col >= w) begin
         next_col = 0;
         next_row++;
         if (next_row >= h) next_row = 0;
      end
      return n;
   endfunction

   function automatic void note_mismatch(string what, filt_word_type e, filt_word_type a);
      errors++;
      if (errors <= 10)
         $display("%0t: %s exp pix=%0d col=%0d row=%0d last=%0b done=%0b | %s",
                  $realtime, what, e.pix, e.col, e.row, e.last, e.done,
                  $sformatf("got pix=%0d col=%0d row=%0d last=%0b done=%0b",
                            a.pix, a.col, a.row, a.last, a.done));
   endfunction

   // ---------------------------------------------------------------
   // Register writes (block idle only); set_frame drops the enable
   // ---------------------------------------------------------------
   task automatic write_csr(wf3_pkg::csr_idx_type idx, logic [10:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         wf3_pkg::CSR_FRAME_WIDTH:  shadow_width  = val;
         wf3_pkg::CSR_FRAME_HEIGHT: shadow_height = val;
         wf3_pkg::CSR_FILTER_MODE:  shadow_mode   = val[0];
         default: ;
      endcase
   endtask

   task automatic set_frame(logic [10:0] w, logic [10:0] h, logic m);
      write_csr(wf3_pkg::CSR_FRAME_WIDTH, w);
      write_csr(wf3_pkg::CSR_FRAME_HEIGHT, h);
      write_csr(wf3_pkg::CSR_FILTER_MODE, {10'd0, m});
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Sender: drives at the rising edge, samples tready mid-cycle
   // ---------------------------------------------------------------
   task automatic send_pixel(wf3_pkg::pix_type pix, logic fs, int want);
      logic ok;
      int   n;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tuser  <= fs;
      do begin
         @(negedge clock);
         ok = req_tready;
         @(posedge clock);
      end while (!ok);
      words_in++;
      n = filter_pixel(pix, fs);
      // directed rows with a value that can be read off directly
      if (want >= 0)
         for (int i = 1; i <= n; i++)
            if (pending_q[pending_q.size() - i].pix != wf3_pkg::pix_type'(want)) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: predicted %0d, table says %0d", $realtime,
                           pending_q[pending_q.size() - i].pix, want);
            end
   endtask

   // waits until every owed result is back, then lets the pipeline go quiet
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // well-formed frames with random content, a little mid-frame frame_start noise
   task automatic random_frames(int count);
      wf3_pkg::pix_type p;
      logic             fs;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(9))
            0:       p = 8'h00;
            1:       p = 8'hFF;
            default: p = wf3_pkg::pix_type'($urandom);
         endcase
         fs = (i == 0) || ($urandom_range(99) < 3);
         send_pixel(p, fs, -1);
      end
   endtask

   // ---------------------------------------------------------------
   // Receiver: random tready, optional long hold-off, check on accept
   // ---------------------------------------------------------------
   initial begin
      logic          got;
      filt_word_type seen, want;
      got = 1'b0;
      forever begin
         @(posedge clock);
         if (got) begin
            words_out++;
            if (seen.done) frames_seen++;
            if (pending_q.size() == 0) begin
               want = '{default: '0};
               note_mismatch("unexpected word", want, seen);
            end else begin
               want = pending_q.pop_front();
               if (seen.pix != want.pix || seen.col != want.col || seen.row != want.row ||
                   seen.last != want.last || seen.done != want.done)
                  note_mismatch("mismatch", want, seen);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
         @(negedge clock);
         got       = rsp_tvalid && rsp_tready && !reset;
         seen.pix  = rsp_tdata[7:0];
         seen.col  = rsp_tdata[17:8];
         seen.row  = rsp_tdata[27:18];
         seen.last = rsp_tlast;
         seen.done = rsp_tuser[0];
      end
   end

   // Watchdog: counts cycles in which no word moves on either side.
   int quiet_cycles = 0;
   always @(negedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_MAX) begin
         $display("watchdog: no progress for %0d cycles", STALL_MAX);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // ---------------------------------------------------------------
   // Directed table: 4x4 frame of 255, then the start of a frame of 0
   // ---------------------------------------------------------------
   stim_row_type dir_tab [25];

   initial begin
      errors = 0;
      words_in = 0;
      words_out = 0;
      frames_seen = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_left = 0;
      shadow_width = 640;
      shadow_height = 480;
      shadow_mode = 1'b0;
      next_col = 0;
      next_row = 0;
      foreach (win_px[i]) win_px[i] = '0;
      foreach (upper_line[i]) begin
         upper_line[i] = '0;
         lower_line[i] = '0;
      end
      // all-white frame: every window result (rows/cols >= 2) must be 255
      for (int i = 0; i < 16; i++)
         dir_tab[i] = '{255, (i == 0), ((i % 4) >= 2 && (i / 4) >= 2) ? 255 : -1};
      // black frame start: first two rows and column 0 of row 2 give nothing
      for (int i = 16; i < 25; i++)
         dir_tab[i] = '{0, (i == 16), -1};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // width/height 3 behave as 4
      set_frame(11'd3, 11'd3, 1'b0);
      foreach (dir_tab[i]) send_pixel(dir_tab[i].pix, dir_tab[i].fs, dir_tab[i].want);
      drain();

      // no idling, median
      set_frame(11'd5, 11'd4, 1'b0);
      random_frames(45);
      drain();

      // sender idles, mean
      send_idle_pct = 57;
      set_frame(11'd4, 11'd6, 1'b1);
      random_frames(45);
      drain();

      // receiver stalls, with one long hold-off so the job queue fills
      send_idle_pct = 0;
      recv_stall_pct = 57;
      set_frame(11'd7, 11'd5, 1'b0);
      hold_left = 300;
      random_frames(50);
      drain();

      // both sides idle; zero sizes clamp to 4
      send_idle_pct = 37;
      recv_stall_pct = 37;
      set_frame(11'd0, 11'd0, 1'b1);
      random_frames(45);
      drain();

      // widest line: 2047 clamps to 1024, first pixels of the line only
      send_idle_pct = 0;
      recv_stall_pct = 0;
      set_frame(11'd2047, 11'd4, 1'b0);
      random_frames(20);
      drain();

      // tallest frame, mean
      set_frame(11'd6, 11'd1024, 1'b1);
      random_frames(40);
      drain();

      $display("%0d pixels in, %0d filtered words out, %0d frame ends; sizes 4..1024",
               words_in, words_out, frames_seen);
      $display("median and mean, idle/stall mixes, long output hold-off; %0d errors",
               errors);
      if (errors == 0 && pending_q.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
